// ===== rtl/level_percent_hysteresis_switch_core_macros.svh =====
// ----------------------------------------------------------------------------
// Level switch assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef LEVEL_PERCENT_HYSTERESIS_SWITCH_CORE_MACROS_SVH
`define LEVEL_PERCENT_HYSTERESIS_SWITCH_CORE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define LPHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// Level switch package
// Widths, register indexes, button action codes and shared types.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int COUNT_W = 16;                 // raw charge-time count
   localparam int PCT_W   = 7;                  // percentage 0..100
   localparam int NUM_W   = COUNT_W + PCT_W;    // (raw - min) * 100 fits here
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT1_ON   = 3'd0,
      CSR_OUT1_OFF  = 3'd1,
      CSR_OUT2_ON   = 3'd2,
      CSR_OUT2_OFF  = 3'd3,
      CSR_INVERT    = 3'd4,
      CSR_BTN1_ACT  = 3'd5,
      CSR_BTN2_ACT  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_CAL_MIN  = 3'd1,
      ACT_CAL_MAX  = 3'd2,
      ACT_OUT1_ON  = 3'd3,
      ACT_OUT1_OFF = 3'd4,
      ACT_OUT2_ON  = 3'd5,
      ACT_OUT2_OFF = 3'd6
   } action_type;

   // Divider request and status
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0]   numerator;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] quotient;
   } div_rsp_type;

   // Switch and calibration state as updated by hysteresis and the buttons
   typedef struct packed {
      logic               sw1;
      logic               sw2;
      logic [COUNT_W-1:0] cal_min;
      logic [COUNT_W-1:0] cal_max;
   } ctl_state_type;

endpackage

// ===== rtl/lphs_div.sv =====
// ----------------------------------------------------------------------------
// Level switch divider
// Restoring divider producing a 7-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module lphs_div
   import lphs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int DSH_W = COUNT_W + PCT_W - 1;
   localparam int CNT_W = $clog2(PCT_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic [NUM_W-1:0]   rem_ff,  rem_in;
   logic [DSH_W-1:0]   dsh_ff,  dsh_in;
   logic [PCT_W-1:0]   quot_ff, quot_in;
   logic               fits;

   // The quotient is known to stay below 128, so start with the divisor
   // aligned to the top quotient bit.
   assign fits = rem_ff >= {1'b0, dsh_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.numerator;
         dsh_in  = {div_req.divisor, {(PCT_W-1){1'b0}}};
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - NUM_W'(dsh_ff);
         end
         quot_in = {quot_ff[PCT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PCT_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// ===== rtl/level_percent_hysteresis_switch_core.sv =====
// ----------------------------------------------------------------------------
// Level percent hysteresis switch
// Scales a charge-time count to a percentage and drives two switches.
// ----------------------------------------------------------------------------
// Each request carries a raw count and two active-low button levels and
// yields one response: the percentage between the calibration limits
// (clamped to 0 or 100) and the new state of both switches. A request is
// taken only while the block is idle. One that needs scaling passes through
// the scale, divide and finish states, the seven-step restoring divider
// giving one quotient bit per cycle; a count at or outside the calibration
// limits skips the divider and goes from scale straight to finish. A response
// waiting in the output register does not block the next request; it only
// holds the final step of the one after. Configuration is to be written only
// while idle, which the block itself does not enforce; a write is always taken.
module level_percent_hysteresis_switch_core
   import lphs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COUNT_W-1:0]    req_raw_count,
   input  logic                  req_button1_level,
   input  logic                  req_button2_level,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PCT_W-1:0]      rsp_level_percent,
   output logic                  rsp_switch1,
   output logic                  rsp_switch2,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCALE  = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // configuration registers
   logic [PCT_W-1:0]   out1_on_ff, out1_off_ff, out2_on_ff, out2_off_ff;
   logic [1:0]         invert_ff;
   action_type         btn1_act_ff, btn2_act_ff;

   // block state
   state_type          state_ff, state_in;
   ctl_state_type      ctl_ff, ctl_in;
   logic               prev_btn1_ff, prev_btn2_ff;

   // request and working payload
   logic [COUNT_W-1:0] raw_ff;
   logic               btn1_ff, btn2_ff;
   logic [PCT_W-1:0]   pct_ff, pct_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]   rsp_pct_ff;
   logic               rsp_sw1_ff, rsp_sw2_ff;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               div_start;

   logic               req_take;
   logic               out_free;
   logic               finish_go;
   logic [COUNT_W-1:0] span;
   logic [NUM_W-1:0]   delta;

   function automatic logic hyst(input logic cur, input logic [PCT_W-1:0] pct,
                                 input logic [PCT_W-1:0] on_lvl,
                                 input logic [PCT_W-1:0] off_lvl, input logic inv);
      logic r;
      r = cur;
      if (on_lvl > off_lvl) begin
         if (pct >= on_lvl) r = 1'b1;
         if (pct <= off_lvl) r = 1'b0;
      end else if (on_lvl < off_lvl) begin
         if (pct <= on_lvl) r = 1'b1;
         if (pct >= off_lvl) r = 1'b0;
      end else begin
         r = (pct > on_lvl) ^ inv;
      end
      return r;
   endfunction

   function automatic ctl_state_type apply_button(input ctl_state_type st,
                                                  input logic level, input logic prev,
                                                  input action_type act,
                                                  input logic [COUNT_W-1:0] raw);
      ctl_state_type r;
      logic          cal_ok;
      r      = st;
      cal_ok = prev && (raw != '0);
      if (!level) begin
         unique case (act)
            ACT_CAL_MIN:  if (cal_ok) r.cal_min = raw;
            ACT_CAL_MAX:  if (cal_ok) r.cal_max = raw;
            ACT_OUT1_ON:  r.sw1 = 1'b1;
            ACT_OUT1_OFF: r.sw1 = 1'b0;
            ACT_OUT2_ON:  r.sw2 = 1'b1;
            ACT_OUT2_OFF: r.sw2 = 1'b0;
            default:      r = st;
         endcase
      end
      return r;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish_go = (state_ff == ST_FINISH) && out_free;

   // (raw - min) * 100 as shift-and-add
   assign span  = raw_ff - ctl_ff.cal_min;
   assign delta = (NUM_W'(span) << 6) + (NUM_W'(span) << 5) + (NUM_W'(span) << 2);

   assign div_req.start     = div_start;
   assign div_req.numerator = delta;
   assign div_req.divisor   = ctl_ff.cal_max - ctl_ff.cal_min;

   lphs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in  = state_ff;
      pct_in    = pct_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (raw_ff <= ctl_ff.cal_min) begin
               pct_in   = '0;
               state_in = ST_FINISH;
            end else if (raw_ff >= ctl_ff.cal_max) begin
               pct_in   = PCT_FULL;
               state_in = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hysteresis first, then button one, then button two
   always_comb begin
      ctl_state_type st;
      st         = ctl_ff;
      st.sw1     = hyst(ctl_ff.sw1, pct_ff, out1_on_ff, out1_off_ff, invert_ff[0]);
      st.sw2     = hyst(ctl_ff.sw2, pct_ff, out2_on_ff, out2_off_ff, invert_ff[1]);
      st         = apply_button(st, btn1_ff, prev_btn1_ff, btn1_act_ff, raw_ff);
      st         = apply_button(st, btn2_ff, prev_btn2_ff, btn2_act_ff, raw_ff);
      ctl_in     = st;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (finish_go) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         ctl_ff.sw1    <= 1'b0;
         ctl_ff.sw2    <= 1'b0;
         ctl_ff.cal_min <= '0;
         ctl_ff.cal_max <= '1;
         prev_btn1_ff  <= 1'b0;
         prev_btn2_ff  <= 1'b0;
         out1_on_ff    <= '0;
         out1_off_ff   <= '0;
         out2_on_ff    <= '0;
         out2_off_ff   <= '0;
         invert_ff     <= '0;
         btn1_act_ff   <= ACT_NONE;
         btn2_act_ff   <= ACT_NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish_go) begin
            ctl_ff       <= ctl_in;
            prev_btn1_ff <= btn1_ff;
            prev_btn2_ff <= btn2_ff;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_OUT1_ON:  out1_on_ff  <= csr_wdata[PCT_W-1:0];
               CSR_OUT1_OFF: out1_off_ff <= csr_wdata[PCT_W-1:0];
               CSR_OUT2_ON:  out2_on_ff  <= csr_wdata[PCT_W-1:0];
               CSR_OUT2_OFF: out2_off_ff <= csr_wdata[PCT_W-1:0];
               CSR_INVERT:   invert_ff   <= csr_wdata[1:0];
               CSR_BTN1_ACT: btn1_act_ff <= action_type'(csr_wdata[2:0]);
               CSR_BTN2_ACT: btn2_act_ff <= action_type'(csr_wdata[2:0]);
               default:      ; // drop writes beyond the register list
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff  <= req_raw_count;
         btn1_ff <= req_button1_level;
         btn2_ff <= req_button2_level;
      end
      pct_ff <= pct_in;
      if (finish_go) begin
         rsp_pct_ff <= pct_ff;
         rsp_sw1_ff <= ctl_in.sw1;
         rsp_sw2_ff <= ctl_in.sw2;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_percent = rsp_pct_ff;
   assign rsp_switch1       = rsp_sw1_ff;
   assign rsp_switch2       = rsp_sw2_ff;

endmodule

// ===== rtl/lphs_checker.sv =====
// ----------------------------------------------------------------------------
// Level switch port checker
// Watches the ports of the level switch core over time.
// ----------------------------------------------------------------------------
`include "level_percent_hysteresis_switch_core_macros.svh"

module lphs_checker
   import lphs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PCT_W-1:0]      rsp_level_percent,
   input logic                  rsp_switch1,
   input logic                  rsp_switch2,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   logic req_take;
   logic rsp_stall;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled response holds
   `LPHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_level_percent) && $stable(rsp_switch1)
      && $stable(rsp_switch2), "response changed while stalled")

   // the percentage never leaves its range
   `LPHS_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid,
      rsp_level_percent <= PCT_FULL, "level above 100 percent")

   // one request at a time: busy after taking one
   `LPHS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_take,
      !req_ready, "request taken while previous still in progress")

   // configuration is always taken
   `LPHS_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid,
      csr_ready, "configuration write stalled")

endmodule

bind level_percent_hysteresis_switch_core lphs_checker u_lphs_checker (.*);
